FILE: hw/rtl/lrl_pkg.sv
package lrl_pkg;

  localparam int unsigned ENTRIES  = 16;
  localparam int unsigned KEY_BITS = 32;

  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned RANK_W = IDX_W;
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);

  // field widths of the stream payload
  localparam int unsigned KEY_FIELD_W   = 32;
  localparam int unsigned COUNT_FIELD_W = 5;

  typedef enum logic {
    OP_TOUCH  = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // latch the input item, restart scan
    logic scan_run;  // key scan in progress
    logic update;    // apply list change
    logic head;      // look up least-recent slot
    logic load;      // move result into output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } ctrl_stat_t;

endpackage

FILE: hw/rtl/lru_recency_list.sv
// LRU recency list: holds up to ENTRIES distinct keys ordered from least to
// most recently used.
// Input stream (s_axis): tuser[0] is the op (0 touch, 1 remove), tdata is the
// key. A touch moves a present key to the most-recent end, or appends an
// absent key there; on a full list the key is dropped and flagged. A remove
// deletes the key wherever it stands, or reports not found.
// Output stream (m_axis): exactly one transfer per input transfer, carrying
// status, the current least-recent key and the number of keys held.
// Timing: one item at a time. After an input transfer the key store RAM is
// scanned one slot per cycle through its single read port, then the ranks
// are updated, the head key is read and the output register is loaded. A
// new item is accepted only after the last one has been loaded.
// The output register lets the next item be accepted while a result waits;
// if the receiver stalls, that next item finishes its scan, the update and
// the head read, and then holds until the output register is free.
// Reset: the list comes up empty (count 0, lru_valid 0); the key store is
// not cleared, since only valid slots are ever compared or reported.
module lru_recency_list (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] key
  input  logic [0:0]  s_axis_tuser,  // [0] op
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [31:0] lru_key, [36:32] count, rest zero
  output logic [3:0]  m_axis_tuser   // [2:0] status, [3] lru_valid
);
  import lrl_pkg::*;

  ctrl_cmd_t                cmd;
  ctrl_stat_t               stat;
  status_e                  out_status;
  logic                     out_lru_valid;
  logic [KEY_FIELD_W-1:0]   out_lru_key;
  logic [COUNT_FIELD_W-1:0] out_count;

  // sequencer: accept, scan, update, head lookup, result load
  lrl_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  // key store, valid bits, ranks, count and output register
  lrl_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .op_i            (s_axis_tuser[0]),
    .key_i           (s_axis_tdata),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_status_o    (out_status),
    .out_lru_valid_o (out_lru_valid),
    .out_lru_key_o   (out_lru_key),
    .out_count_o     (out_count)
  );

  assign m_axis_tdata = {3'b000, out_count, out_lru_key};
  assign m_axis_tuser = {out_lru_valid, out_status};

endmodule

FILE: hw/rtl/lrl_ram.sv
module lrl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/lrl_ctrl.sv
module lrl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  lrl_pkg::ctrl_stat_t stat_i,
  output lrl_pkg::ctrl_cmd_t  cmd_o
);
  import lrl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_UPDATE = 5'b00100,
    S_HEAD   = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.accept = 1'b1;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_HEAD;
      end
      S_HEAD: begin
        cmd_o.head = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        // hold until the output register can take the result
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/lrl_datapath.sv
module lrl_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lrl_pkg::ctrl_cmd_t                  cmd_i,
  output lrl_pkg::ctrl_stat_t                 stat_o,
  input  logic                                op_i,
  input  logic [lrl_pkg::KEY_FIELD_W-1:0]     key_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output lrl_pkg::status_e                    out_status_o,
  output logic                                out_lru_valid_o,
  output logic [lrl_pkg::KEY_FIELD_W-1:0]     out_lru_key_o,
  output logic [lrl_pkg::COUNT_FIELD_W-1:0]   out_count_o
);
  import lrl_pkg::*;

  localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(ENTRIES);

  // item registers
  op_e                 op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [KEY_FIELD_W+KEY_BITS-1:0] key_ext;

  // scan
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic             free_found_q, free_found_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic             scan_rd;

  // list state
  logic              valid_q [ENTRIES];
  logic              valid_d [ENTRIES];
  logic [RANK_W-1:0] rank_q  [ENTRIES];
  logic [RANK_W-1:0] rank_d  [ENTRIES];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  count_m1;
  logic [RANK_W-1:0] hit_rank;
  status_e           status_q, status_d;

  // head lookup
  logic [ENTRIES-1:0] head_oh;
  logic [IDX_W-1:0]   head_idx;
  logic               lv_q;

  // key store
  logic                we;
  logic [IDX_W-1:0]    raddr;
  logic                re;
  logic [KEY_BITS-1:0] rdata;

  // output register
  logic                     out_valid_q;
  status_e                  out_status_q;
  logic                     out_lv_q;
  logic [KEY_FIELD_W-1:0]   out_key_q;
  logic [COUNT_FIELD_W-1:0] out_count_q;
  logic [KEY_BITS+KEY_FIELD_W-1:0]   lru_ext;
  logic [CNT_W+COUNT_FIELD_W-1:0]    cnt_ext;

  assign key_ext = {{KEY_BITS{1'b0}}, key_i};

  // ---------------- scan ----------------
  assign scan_rd = cmd_i.scan_run && (cnt_q < ENTRIES_C);

  always_comb begin
    cnt_d        = cnt_q;
    cmp_vld_d    = scan_rd;
    cmp_idx_d    = cnt_q[IDX_W-1:0];
    found_d      = found_q;
    hit_idx_d    = hit_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    if (cmd_i.accept) begin
      cnt_d        = '0;
      cmp_vld_d    = 1'b0;
      found_d      = 1'b0;
      free_found_d = 1'b0;
    end else begin
      if (scan_rd) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
      // compare the key read last cycle
      if (cmp_vld_q) begin
        if (valid_q[cmp_idx_q] && (rdata == key_q) && !found_q) begin
          found_d   = 1'b1;
          hit_idx_d = cmp_idx_q;
        end
        if (!valid_q[cmp_idx_q] && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = cmp_idx_q;
        end
      end
    end
  end

  assign stat_o.scan_done = (cnt_q == ENTRIES_C);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  // ---------------- update ----------------
  assign count_m1 = count_q - CNT_W'(1);
  assign hit_rank = rank_q[hit_idx_q];

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      valid_d[i] = valid_q[i];
      rank_d[i]  = rank_q[i];
    end
    count_d  = count_q;
    status_d = status_q;
    we       = 1'b0;
    if (cmd_i.update) begin
      if (op_q == OP_TOUCH) begin
        if (found_q) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_q[i] && (rank_q[i] > hit_rank)) begin
              rank_d[i] = rank_q[i] - RANK_W'(1);
            end
          end
          rank_d[hit_idx_q] = count_m1[RANK_W-1:0];
          status_d          = ST_HIT;
        end else if ((count_q < ENTRIES_C) && free_found_q) begin
          valid_d[free_idx_q] = 1'b1;
          rank_d[free_idx_q]  = count_q[RANK_W-1:0];
          count_d             = count_q + CNT_W'(1);
          we                  = 1'b1;
          status_d            = ST_INSERTED;
        end else begin
          status_d = ST_FULL;
        end
      end else begin
        if (found_q) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_q[i] && (rank_q[i] > hit_rank)) begin
              rank_d[i] = rank_q[i] - RANK_W'(1);
            end
          end
          valid_d[hit_idx_q] = 1'b0;
          rank_d[hit_idx_q]  = '0;
          count_d            = count_m1;
          status_d           = ST_REMOVED;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
    end
  end

  // ---------------- head lookup ----------------
  always_comb begin
    head_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      head_oh[i] = valid_q[i] && (rank_q[i] == '0);
      if (head_oh[i]) begin
        head_idx = head_idx | IDX_W'(i);
      end
    end
  end

  assign re    = scan_rd || cmd_i.head;
  assign raddr = cmd_i.head ? head_idx : cnt_q[IDX_W-1:0];

  lrl_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (ENTRIES)
  ) u_key_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (free_idx_q),
    .wdata_i (key_q),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      cmp_vld_q    <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      count_q      <= '0;
      lv_q         <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
        rank_q[i]  <= '0;
      end
    end else begin
      cnt_q        <= cnt_d;
      cmp_vld_q    <= cmp_vld_d;
      found_q      <= found_d;
      free_found_q <= free_found_d;
      count_q      <= count_d;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= valid_d[i];
        rank_q[i]  <= rank_d[i];
      end
      if (cmd_i.head) begin
        lv_q <= |head_oh;
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign lru_ext = {{KEY_FIELD_W{1'b0}}, rdata};
  assign cnt_ext = {{COUNT_FIELD_W{1'b0}}, count_q};

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    status_q   <= status_d;
    if (cmd_i.accept) begin
      op_q  <= op_e'(op_i);
      key_q <= key_ext[KEY_BITS-1:0];
    end
    if (cmd_i.load) begin
      out_status_q <= status_q;
      out_lv_q     <= lv_q;
      out_key_q    <= lv_q ? lru_ext[KEY_FIELD_W-1:0] : '0;
      out_count_q  <= cnt_ext[COUNT_FIELD_W-1:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_status_o    = out_status_q;
  assign out_lru_valid_o = out_lv_q;
  assign out_lru_key_o   = out_key_q;
  assign out_count_o     = out_count_q;

endmodule

FILE: verif/lru_recency_list_test.sv
// Block-level test for the LRU recency list.
// A directed table first covers the corner cases: an empty list, the extreme
// key values, a hit, a hit on the most recent key, removes, a fill to capacity
// and a dropped key on a full list. Random traffic follows. It draws mostly on
// a small pool of keys, so that hits, removes and full drops all occur often.
// Every accepted input transfer goes through a local list model. The result
// stream is checked field by field, in order, against the queued results.
module lru_recency_list_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lrl_pkg::*;

  // one expected output transfer
  typedef struct packed {
    status_e              status;
    logic                 lru_valid;
    logic [31:0]          lru_key;
    logic [CNT_W-1:0]     count;
  } result_t;

  // one row of the directed table; reps > 1 sends key, key+1, ... in a row
  typedef struct {
    op_e         op;
    logic [31:0] key;
    int unsigned reps;
    bit          typed;   // use the hand-written result instead of the model
    result_t     want;
  } probe_t;

  localparam int unsigned N_PROBES = 15;
  localparam int unsigned POOL_SZ  = 20;
  localparam int unsigned N_RANDOM = 1150;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] key
  logic [0:0]  s_axis_tuser;   // [0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [31:0] lru_key, [36:32] count
  logic [3:0]  m_axis_tuser;   // [2:0] status, [3] lru_valid

  lru_recency_list dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // List model: one slot per entry, each with a key, a used flag and a rank
  // (0 = least recent, held-1 = most recent).
  // ---------------------------------------------------------------------------
  logic [31:0] slot_key  [ENTRIES];
  bit          slot_used [ENTRIES];
  int unsigned slot_rank [ENTRIES];
  int unsigned held;

  result_t     pending[$];   // results still owed by the block, oldest first
  int unsigned mismatches;
  int unsigned src_idle_pct; // chance per cycle that the sender holds off
  int unsigned snk_idle_pct; // chance per cycle that the receiver stalls

  // every used slot ranked above r moves one step toward the LRU end
  function automatic void close_gap(int unsigned r);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] && slot_rank[i] > r) begin
        slot_rank[i]--;
      end
    end
  endfunction

  function automatic result_t list_step(op_e op, logic [31:0] key);
    int      hit;
    int      free_slot;
    result_t res;
    hit       = -1;
    free_slot = -1;
    res       = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] && slot_key[i] == key && hit < 0) hit = i;
      if (!slot_used[i] && free_slot < 0) free_slot = i;
    end
    if (op == OP_TOUCH) begin
      if (hit >= 0) begin
        // hit: move to the MRU end (no change if it is already there)
        close_gap(slot_rank[hit]);
        slot_rank[hit] = held - 1;
        res.status = ST_HIT;
      end else if (held < ENTRIES) begin
        // miss with room: append at the MRU end
        slot_used[free_slot] = 1'b1;
        slot_key[free_slot]  = key;
        slot_rank[free_slot] = held;
        held++;
        res.status = ST_INSERTED;
      end else begin
        res.status = ST_FULL;   // miss on a full list: key is dropped
      end
    end else if (hit >= 0) begin
      slot_used[hit] = 1'b0;
      close_gap(slot_rank[hit]);
      slot_rank[hit] = 0;
      held--;
      res.status = ST_REMOVED;
    end else begin
      res.status = ST_NOT_FOUND;
    end
    // head of the list; key reads as zero when the list is empty
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] && slot_rank[i] == 0 && !res.lru_valid) begin
        res.lru_valid = 1'b1;
        res.lru_key   = slot_key[i];
      end
    end
    res.count = CNT_W'(held);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: values change on the falling edge, transfers are taken on the
  // rising edge. The model runs on the edge that accepts the transfer.
  // ---------------------------------------------------------------------------
  task automatic send_item(op_e op, logic [31:0] key, bit typed, result_t want);
    result_t got;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    got = list_step(op, key);
    pending.push_back(typed ? want : got);
  endtask

  // Random traffic: mostly keys from a small pool so the list fills, hits and
  // drains; now and then a fresh key, and the pool slowly turns over.
  task automatic run_random(int unsigned n_items);
    logic [31:0] key_pool [POOL_SZ];
    logic [31:0] key;
    op_e         op;
    for (int i = 0; i < POOL_SZ; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int unsigned n = 0; n < n_items; n++) begin
      if ($urandom_range(0, 49) == 0) key_pool[$urandom_range(0, POOL_SZ - 1)] = $urandom;
      op  = ($urandom_range(0, 99) < 62) ? OP_TOUCH : OP_REMOVE;
      key = ($urandom_range(0, 99) < 88) ? key_pool[$urandom_range(0, POOL_SZ - 1)]
                                          : 32'($urandom);
      send_item(op, key, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random backpressure, set on the falling edge; held low in reset
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end else begin
      m_axis_tready <= 1'b0;
    end
  end

  function automatic void field_check(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // in-order check of each accepted output transfer
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending.size() == 0) begin
        $error("output transfer with no result outstanding");
        mismatches++;
      end else begin
        want = pending.pop_front();
        field_check("status",    32'(want.status),    32'(m_axis_tuser[2:0]));
        field_check("lru_valid", 32'(want.lru_valid), 32'(m_axis_tuser[3]));
        field_check("lru_key",   want.lru_key,        m_axis_tdata[31:0]);
        field_check("count",     32'(want.count),     32'(m_axis_tdata[36:32]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    probe_t probes [N_PROBES];

    // Directed cases. Typed results are the ones that follow at a glance from
    // the list contents; the fill and the last three rows rely on the model.
    probes = '{
      // remove on an empty list: not found, head reads as zero
      '{OP_REMOVE, 32'h0000_0005, 1,  1'b1, '{ST_NOT_FOUND, 1'b0, 32'h0, 5'd0}},
      '{OP_TOUCH,  32'h0000_0000, 1,  1'b1, '{ST_INSERTED,  1'b1, 32'h0, 5'd1}},
      '{OP_TOUCH,  32'hFFFF_FFFF, 1,  1'b1, '{ST_INSERTED,  1'b1, 32'h0, 5'd2}},
      // hit on the LRU key moves it to the MRU end
      '{OP_TOUCH,  32'h0000_0000, 1,  1'b1, '{ST_HIT, 1'b1, 32'hFFFF_FFFF, 5'd2}},
      // hit on the MRU key leaves the order alone
      '{OP_TOUCH,  32'h0000_0000, 1,  1'b1, '{ST_HIT, 1'b1, 32'hFFFF_FFFF, 5'd2}},
      // remove of an absent key on a non-empty list
      '{OP_REMOVE, 32'h0001_2345, 1,  1'b1, '{ST_NOT_FOUND, 1'b1, 32'hFFFF_FFFF, 5'd2}},
      '{OP_REMOVE, 32'hFFFF_FFFF, 1,  1'b1, '{ST_REMOVED,   1'b1, 32'h0, 5'd1}},
      '{OP_TOUCH,  32'hAAAA_AAAA, 1,  1'b1, '{ST_INSERTED,  1'b1, 32'h0, 5'd2}},
      '{OP_TOUCH,  32'h5555_5555, 1,  1'b1, '{ST_INSERTED,  1'b1, 32'h0, 5'd3}},
      // fill up to capacity
      '{OP_TOUCH,  32'h0000_0001, 13, 1'b0, '0},
      // miss on a full list: key dropped, nothing changes
      '{OP_TOUCH,  32'hFFFF_FFFF, 1,  1'b1, '{ST_FULL, 1'b1, 32'h0, 5'd16}},
      '{OP_TOUCH,  32'h0000_0000, 1,  1'b1, '{ST_HIT,  1'b1, 32'hAAAA_AAAA, 5'd16}},
      // remove from the middle, refill, then remove the key that was MRU before the refill
      '{OP_REMOVE, 32'h0000_0007, 1,  1'b0, '0},
      '{OP_TOUCH,  32'h8000_0000, 1,  1'b0, '0},
      '{OP_REMOVE, 32'h0000_0000, 1,  1'b0, '0}
    };

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    mismatches    = 0;
    held          = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_key[i]  = '0;
      slot_used[i] = 1'b0;
      slot_rank[i] = 0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // phase 1: sender mostly busy, receiver stalls a lot
    src_idle_pct = 9;
    snk_idle_pct = 76;
    foreach (probes[p]) begin
      for (int unsigned j = 0; j < probes[p].reps; j++) begin
        send_item(probes[p].op, probes[p].key + j, probes[p].typed, probes[p].want);
      end
    end
    run_random(N_RANDOM / 3);

    // phase 2: roles swapped
    src_idle_pct = 76;
    snk_idle_pct = 9;
    run_random(N_RANDOM / 3);

    // phase 3: full rate on both sides
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random(N_RANDOM - 2 * (N_RANDOM / 3));

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // drain, then keep watching for any stray transfer
    while (pending.size() != 0) @(posedge clk_i);
    repeat (2 * ENTRIES + 8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog: many times the slowest expected run
  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/lrl_pkg.sv
hw/rtl/lrl_ram.sv
hw/rtl/lrl_ctrl.sv
hw/rtl/lrl_datapath.sv
hw/rtl/lru_recency_list.sv
verif/lru_recency_list_test.sv
